[sv/alut_pkg.sv]
package alut_pkg;

    localparam int CODE_BITS  = 12;
    localparam int AVG_BITS   = 24;
    localparam int STEP_BITS  = 8;
    localparam int MODE_BITS  = 2;
    localparam int COARSE     = 256;
    localparam int TBL_DEPTH  = 4096;
    localparam int SEG_POINTS = 80;          // curve points per step times fine points
    localparam int IDX_BITS   = 15;          // fine point index, 0..20479
    localparam int VAL_BITS   = 31;          // fine point value
    localparam int F_BITS     = 32;
    localparam int D_BITS     = 25;          // signed step difference
    localparam int NUM_BITS   = 28;
    localparam int PROD_BITS  = 57;

    localparam logic [CODE_BITS-1:0] CODE_MAX  = 12'hFFF;
    localparam logic [AVG_BITS-1:0]  AVG_FULL  = 24'hFFF000;  // full scale code in Q12
    localparam logic [F_BITS-1:0]    F_HALF    = 32'd163840;  // one half, times fine scale
    localparam logic [28:0]          RECIP10   = 29'd429496730;
    localparam logic [15:0]          RECIP5    = 16'd52429;
    localparam logic [6:0]           PT_LAST   = 7'd79;
    localparam logic [STEP_BITS-1:0] SEG_LAST  = 8'd255;

    localparam logic [MODE_BITS-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_BUILD  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_READ   = 2'd2;

    localparam logic KIND_BUILT = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic [STEP_BITS-1:0] dac_step;
        logic [CODE_BITS-1:0] adc_sample;
        logic [CODE_BITS-1:0] entry_addr;
    } in_t;

    typedef struct packed {
        logic                 result_kind;
        logic [CODE_BITS-1:0] corrected_code;
    } out_t;

    typedef struct packed {
        logic                ok;
        logic [VAL_BITS-1:0] val;
        logic [IDX_BITS-1:0] idx;
    } cand_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SMP_RD, ST_SMP_NUM, ST_SMP_MUL, ST_SMP_WR,
        ST_RD_REQ, ST_RD_OUT, ST_CLR, ST_SEG_LD0, ST_SEG_INIT,
        ST_SEG_RD, ST_SEG_D, ST_PT_DIV, ST_PT_RD, ST_PT_WR,
        ST_SFX_RD, ST_SFX_WR, ST_FIL_RD, ST_FIL_A, ST_FIL_B,
        ST_FIL_WR, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SMP_RD, OP_SMP_NUM, OP_SMP_MUL, OP_SMP_WR,
        OP_RD_REQ, OP_RD_OUT, OP_CLR, OP_SEG_LD0, OP_SEG_INIT,
        OP_SEG_RD, OP_SEG_D, OP_PT_DIV, OP_PT_RD, OP_PT_WR,
        OP_SFX_RD, OP_SFX_WR, OP_FIL_RD, OP_FIL_A, OP_FIL_B,
        OP_FIL_WR, OP_DONE
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic cnt_max;
        logic cnt_zero;
        logic seg_last;
        logic pt_last;
    } status_t;

endpackage

[sv/alut_ctrl.sv]
module alut_ctrl
    import alut_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MODE_BITS-1:0] mode,
    input  status_t              status,
    output cmd_t                 cmd,
    output logic                 busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (mode)
                        MODE_SAMPLE: state_next = ST_SMP_RD;
                        MODE_BUILD:  state_next = ST_CLR;
                        MODE_READ:   state_next = ST_RD_REQ;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SMP_RD:   state_next = ST_SMP_NUM;
            ST_SMP_NUM:  state_next = ST_SMP_MUL;
            ST_SMP_MUL:  state_next = ST_SMP_WR;
            ST_SMP_WR:   state_next = ST_IDLE;
            ST_RD_REQ:   state_next = ST_RD_OUT;
            ST_RD_OUT:   state_next = ST_IDLE;
            ST_CLR:      state_next = status.cnt_max ? ST_SEG_LD0 : ST_CLR;
            ST_SEG_LD0:  state_next = ST_SEG_INIT;
            ST_SEG_INIT: state_next = ST_SEG_RD;
            ST_SEG_RD:   state_next = ST_SEG_D;
            ST_SEG_D:    state_next = ST_PT_DIV;
            ST_PT_DIV:   state_next = ST_PT_RD;
            ST_PT_RD:    state_next = ST_PT_WR;
            ST_PT_WR:
            begin
                if (status.pt_last)
                begin
                    state_next = status.seg_last ? ST_SFX_RD : ST_SEG_RD;
                end
                else
                begin
                    state_next = ST_PT_DIV;
                end
            end
            ST_SFX_RD:   state_next = ST_SFX_WR;
            ST_SFX_WR:   state_next = status.cnt_zero ? ST_FIL_RD : ST_SFX_RD;
            ST_FIL_RD:   state_next = ST_FIL_A;
            ST_FIL_A:    state_next = ST_FIL_B;
            ST_FIL_B:    state_next = ST_FIL_WR;
            ST_FIL_WR:   state_next = status.cnt_max ? ST_DONE : ST_FIL_RD;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy   = (state_reg != ST_IDLE);
        cmd.op = OP_NONE;
        case (state_reg)
            ST_IDLE:     cmd.op = start ? OP_LOAD : OP_NONE;
            ST_SMP_RD:   cmd.op = OP_SMP_RD;
            ST_SMP_NUM:  cmd.op = OP_SMP_NUM;
            ST_SMP_MUL:  cmd.op = OP_SMP_MUL;
            ST_SMP_WR:   cmd.op = OP_SMP_WR;
            ST_RD_REQ:   cmd.op = OP_RD_REQ;
            ST_RD_OUT:   cmd.op = OP_RD_OUT;
            ST_CLR:      cmd.op = OP_CLR;
            ST_SEG_LD0:  cmd.op = OP_SEG_LD0;
            ST_SEG_INIT: cmd.op = OP_SEG_INIT;
            ST_SEG_RD:   cmd.op = OP_SEG_RD;
            ST_SEG_D:    cmd.op = OP_SEG_D;
            ST_PT_DIV:   cmd.op = OP_PT_DIV;
            ST_PT_RD:    cmd.op = OP_PT_RD;
            ST_PT_WR:    cmd.op = OP_PT_WR;
            ST_SFX_RD:   cmd.op = OP_SFX_RD;
            ST_SFX_WR:   cmd.op = OP_SFX_WR;
            ST_FIL_RD:   cmd.op = OP_FIL_RD;
            ST_FIL_A:    cmd.op = OP_FIL_A;
            ST_FIL_B:    cmd.op = OP_FIL_B;
            ST_FIL_WR:   cmd.op = OP_FIL_WR;
            ST_DONE:     cmd.op = OP_DONE;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

[sv/alut_datapath.sv]
module alut_datapath
    import alut_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  in_t     item,
    input  cmd_t    cmd,
    output status_t status,
    output logic    result_strobe,
    output out_t    result
);

    // control registers
    logic [CODE_BITS-1:0] cnt_reg, cnt_next;
    logic [STEP_BITS-1:0] seg_reg, seg_next;
    logic [6:0]           pt_reg, pt_next;
    logic                 built_reg, built_next;
    logic                 strobe_reg, strobe_next;
    logic [COARSE-1:0]    avg_valid_reg, avg_valid_next;

    // payload registers
    in_t                  in_reg, in_next;
    logic [IDX_BITS-1:0]  idx_reg, idx_next;
    logic [F_BITS-1:0]    f_reg, f_next;
    logic signed [D_BITS-1:0] d_reg, d_next;
    logic [AVG_BITS-1:0]  cur_reg, cur_next;
    logic [CODE_BITS-1:0] bucket_reg, bucket_next;
    logic [NUM_BITS-1:0]  num_reg, num_next;
    logic [PROD_BITS-1:0] prod_reg, prod_next;
    cand_t                best_reg, best_next;
    cand_t                below_reg, below_next;
    cand_t                above_reg, above_next;
    logic [IDX_BITS-1:0]  pick_reg, pick_next;
    out_t                 result_reg, result_next;

    // memories
    logic [AVG_BITS-1:0]  avg_mem [COARSE];
    logic [AVG_BITS-1:0]  avg_q;
    logic                 avg_ok_q;
    logic                 avg_we;
    logic [STEP_BITS-1:0] avg_wa, avg_ra;
    logic [AVG_BITS-1:0]  avg_wd;

    cand_t                bmin_mem [TBL_DEPTH];
    cand_t                bmax_mem [TBL_DEPTH];
    cand_t                bmin_q, bmax_q, bmin_wd, bmax_wd;
    logic                 bmin_we, bmax_we;
    logic [CODE_BITS-1:0] bmin_wa, bmax_wa, bmin_ra, bmax_ra;

    logic [CODE_BITS-1:0] tbl_mem [TBL_DEPTH];
    logic [CODE_BITS-1:0] tbl_q, tbl_wa, tbl_wd, tbl_ra;
    logic                 tbl_we;

    // helpers
    logic [AVG_BITS-1:0]  old_avg, nxt_avg;
    logic [30:0]          bprod, sprod;
    logic [12:0]          bq, sq;
    logic [VAL_BITS-1:0]  fv, target;
    logic [14:0]          c5;
    logic signed [32:0]   dl, da;
    cand_t                e;

    always_ff @(posedge clk)
    begin
        if (avg_we)
        begin
            avg_mem[avg_wa] <= avg_wd;
        end
        avg_q <= avg_mem[avg_ra];
    end

    always_ff @(posedge clk)
    begin
        if (bmin_we)
        begin
            bmin_mem[bmin_wa] <= bmin_wd;
        end
        bmin_q <= bmin_mem[bmin_ra];
    end

    always_ff @(posedge clk)
    begin
        if (bmax_we)
        begin
            bmax_mem[bmax_wa] <= bmax_wd;
        end
        bmax_q <= bmax_mem[bmax_ra];
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_wa] <= tbl_wd;
        end
        tbl_q <= tbl_mem[tbl_ra];
    end

    always_comb
    begin
        fv      = f_reg[VAL_BITS-1:0];
        old_avg = avg_ok_q ? avg_q : '0;
        nxt_avg = (seg_reg == SEG_LAST) ? AVG_FULL : old_avg;
        bprod   = 31'(f_reg[30:16]) * 31'(RECIP5);
        bq      = bprod[30:18];
        sprod   = 31'(pick_reg) * 31'(RECIP5);
        sq      = sprod[30:18];
        c5      = 15'({cnt_reg, 2'b00}) + 15'(cnt_reg);
        target  = {c5, 16'b0};
        dl      = $signed({2'b00, target}) - $signed({2'b00, below_reg.val});
        da      = $signed({2'b00, above_reg.val}) - $signed({2'b00, target});
        e       = bmin_q;
        if (best_reg.ok && (!bmin_q.ok || best_reg.val < bmin_q.val
            || (best_reg.val == bmin_q.val && best_reg.idx < bmin_q.idx)))
        begin
            e = best_reg;
        end
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        seg_next       = seg_reg;
        pt_next        = pt_reg;
        built_next     = built_reg;
        strobe_next    = 1'b0;
        avg_valid_next = avg_valid_reg;
        in_next        = in_reg;
        idx_next       = idx_reg;
        f_next         = f_reg;
        d_next         = d_reg;
        cur_next       = cur_reg;
        bucket_next    = bucket_reg;
        num_next       = num_reg;
        prod_next      = prod_reg;
        best_next      = best_reg;
        below_next     = below_reg;
        above_next     = above_reg;
        pick_next      = pick_reg;
        result_next    = result_reg;

        avg_we  = 1'b0;
        avg_wa  = in_reg.dac_step;
        avg_wd  = prod_reg[55:32];
        avg_ra  = in_reg.dac_step;
        bmin_we = 1'b0;
        bmax_we = 1'b0;
        bmin_wa = bucket_reg;
        bmax_wa = bucket_reg;
        bmin_wd = '0;
        bmax_wd = '0;
        bmin_ra = bucket_reg;
        bmax_ra = bucket_reg;
        tbl_we  = 1'b0;
        tbl_wa  = cnt_reg;
        tbl_wd  = '0;
        tbl_ra  = in_reg.entry_addr;

        case (cmd.op)
            OP_LOAD:
            begin
                in_next  = item;
                cnt_next = '0;
            end
            OP_SMP_NUM:
            begin
                // 9 * old + sample in Q12 + 5
                num_next = NUM_BITS'({old_avg, 3'b000}) + NUM_BITS'(old_avg)
                         + NUM_BITS'({in_reg.adc_sample, 12'b0}) + NUM_BITS'(5);
            end
            OP_SMP_MUL:
            begin
                prod_next = PROD_BITS'(num_reg) * PROD_BITS'(RECIP10);
            end
            OP_SMP_WR:
            begin
                avg_we = 1'b1;
                avg_valid_next[in_reg.dac_step] = 1'b1;
            end
            OP_RD_OUT:
            begin
                strobe_next                = 1'b1;
                result_next.result_kind    = KIND_ENTRY;
                result_next.corrected_code = built_reg ? tbl_q : '0;
            end
            OP_CLR:
            begin
                // wipe one bucket of each kind a cycle; pin entry zero
                bmin_we  = 1'b1;
                bmax_we  = 1'b1;
                bmin_wa  = cnt_reg;
                bmax_wa  = cnt_reg;
                tbl_we   = 1'b1;
                tbl_wa   = '0;
                cnt_next = cnt_reg + 1'b1;
            end
            OP_SEG_LD0:
            begin
                avg_ra     = '0;
                cnt_next   = CODE_MAX;
                seg_next   = '0;
                best_next  = '0;
                below_next = '0;
            end
            OP_SEG_INIT:
            begin
                cur_next = old_avg;
                f_next   = F_BITS'({old_avg, 6'b0}) + F_BITS'({old_avg, 4'b0}) + F_HALF;
                idx_next = '0;
            end
            OP_SEG_RD:
            begin
                avg_ra  = seg_reg + 1'b1;
                pt_next = '0;
            end
            OP_SEG_D:
            begin
                d_next   = $signed({1'b0, nxt_avg}) - $signed({1'b0, cur_reg});
                cur_next = nxt_avg;
            end
            OP_PT_DIV:
            begin
                bucket_next = (bq > 13'(CODE_MAX)) ? CODE_MAX : bq[CODE_BITS-1:0];
            end
            OP_PT_WR:
            begin
                if (!bmin_q.ok || fv < bmin_q.val)
                begin
                    bmin_we = 1'b1;
                end
                if (!bmax_q.ok || fv > bmax_q.val)
                begin
                    bmax_we = 1'b1;
                end
                bmin_wd  = '{ok: 1'b1, val: fv, idx: idx_reg};
                bmax_wd  = '{ok: 1'b1, val: fv, idx: idx_reg};
                f_next   = f_reg + F_BITS'(d_reg);
                idx_next = idx_reg + 1'b1;
                pt_next  = pt_reg + 1'b1;
                if (pt_reg == PT_LAST)
                begin
                    seg_next = seg_reg + 1'b1;
                end
            end
            OP_SFX_RD:
            begin
                bmin_ra = cnt_reg;
            end
            OP_SFX_WR:
            begin
                bmin_we   = 1'b1;
                bmin_wa   = cnt_reg;
                bmin_wd   = e;
                best_next = e;
                cnt_next  = (cnt_reg == '0) ? CODE_BITS'(1) : cnt_reg - 1'b1;
            end
            OP_FIL_RD:
            begin
                bmax_ra = cnt_reg - 1'b1;
                bmin_ra = cnt_reg;
            end
            OP_FIL_A:
            begin
                if (bmax_q.ok && (!below_reg.ok || bmax_q.val > below_reg.val))
                begin
                    below_next = bmax_q;
                end
                above_next = bmin_q;
            end
            OP_FIL_B:
            begin
                if (below_reg.ok && above_reg.ok)
                begin
                    if (dl < da)
                    begin
                        pick_next = below_reg.idx;
                    end
                    else if (da < dl)
                    begin
                        pick_next = above_reg.idx;
                    end
                    else
                    begin
                        pick_next = (below_reg.idx < above_reg.idx) ? below_reg.idx
                                                                    : above_reg.idx;
                    end
                end
                else if (below_reg.ok)
                begin
                    pick_next = below_reg.idx;
                end
                else
                begin
                    pick_next = above_reg.idx;
                end
            end
            OP_FIL_WR:
            begin
                tbl_we   = 1'b1;
                tbl_wd   = (sq > 13'(CODE_MAX)) ? CODE_MAX : sq[CODE_BITS-1:0];
                cnt_next = cnt_reg + 1'b1;
            end
            OP_DONE:
            begin
                built_next                 = 1'b1;
                strobe_next                = 1'b1;
                result_next.result_kind    = KIND_BUILT;
                result_next.corrected_code = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            seg_reg       <= '0;
            pt_reg        <= '0;
            built_reg     <= 1'b0;
            strobe_reg    <= 1'b0;
            avg_valid_reg <= '0;
            avg_ok_q      <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            seg_reg       <= seg_next;
            pt_reg        <= pt_next;
            built_reg     <= built_next;
            strobe_reg    <= strobe_next;
            avg_valid_reg <= avg_valid_next;
            avg_ok_q      <= avg_valid_reg[avg_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg     <= in_next;
        idx_reg    <= idx_next;
        f_reg      <= f_next;
        d_reg      <= d_next;
        cur_reg    <= cur_next;
        bucket_reg <= bucket_next;
        num_reg    <= num_next;
        prod_reg   <= prod_next;
        best_reg   <= best_next;
        below_reg  <= below_next;
        above_reg  <= above_next;
        pick_reg   <= pick_next;
        result_reg <= result_next;
    end

    assign status.cnt_max  = (cnt_reg == CODE_MAX);
    assign status.cnt_zero = (cnt_reg == '0);
    assign status.seg_last = (seg_reg == SEG_LAST);
    assign status.pt_last  = (pt_reg == PT_LAST);
    assign result_strobe   = strobe_reg;
    assign result          = result_reg;

endmodule

[sv/adc_linearity_lut_builder.sv]
// ADC linearity correction table builder.
// Input channel: drive item and raise start; the word is taken at a rising
// edge where start is high and busy is low. busy stays high until the block
// can take the next word. item.mode selects: sample (fold adc_sample into
// the running average of dac_step, 0.9 old plus 0.1 new), build (derive the
// correction table from all step averages), or read (fetch one entry).
// Output channel: result_strobe is high for exactly one cycle with result;
// the receiver must take it then, as it cannot hold results off.
// Sequence: a sample steps through read, sum, multiply and write states with
// busy high and gives no result. A read passes a request and an output state
// and raises its result in the cycle busy drops. A build wipes the bucket
// stores, then loads each step and places its fine points (bucket divide,
// registered read, compare and write), then runs the suffix pass and the
// table fill. Its result, result_kind 0, comes in the first cycle with busy
// low.
// Reset clears all step averages (valid bits) and marks the table unbuilt,
// so reads return zero until the first build. Mode 3 words are dropped.
module adc_linearity_lut_builder
    import alut_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  in_t  item,
    output logic busy,
    output logic result_strobe,
    output out_t result
);

    cmd_t    cmd;
    status_t status;

    // sequence the sample, read and build passes
    alut_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (item.mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // hold the averages, bucket stores and table; register the result word
    alut_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .cmd           (cmd),
        .status        (status),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

[sim/adc_linearity_lut_builder_tb.sv]
module adc_linearity_lut_builder_tb
    import alut_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Mode code the block has no use for; words carrying it are dropped.
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    // Fixed point of the build: one code is FINE_SCALE fine units,
    // one half of a curve point is CURVE_HALF curve units.
    localparam longint FINE_SCALE  = 64'd327680;
    localparam longint CURVE_HALF  = 64'd32768;
    localparam int     CURVE_LEN   = COARSE * 16;
    localparam int     FINE_PER    = 5;
    localparam int     BUCKET_CNT  = TBL_DEPTH + 1;
    localparam int     RANDOM_WORDS = 1800;
    localparam int     BUILD_EVERY  = 360;
    localparam longint CYCLE_LIMIT  = 64'd4000000;

    logic clk;
    logic rst_n;
    logic start;
    in_t  item;
    logic busy;
    logic result_strobe;
    out_t result;

    adc_linearity_lut_builder DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .item(item),
        .busy(busy),
        .result_strobe(result_strobe),
        .result(result)
    );

    // One row of the directed part; expected result typed in where obvious.
    typedef struct {
        in_t  word;
        bit   typed;
        out_t typed_out;
    } dir_row_t;

    // Nearest-point candidate used while rebuilding the table.
    typedef struct {
        bit     ok;
        longint val;
        int     idx;
    } near_pt_t;

    logic [AVG_BITS-1:0]  step_avg [COARSE];
    logic [CODE_BITS-1:0] lut_model [TBL_DEPTH];
    near_pt_t             lo_pt [BUCKET_CNT];
    near_pt_t             hi_pt [BUCKET_CNT];

    out_t     pending_results [$];
    dir_row_t dir_rows [$];
    int       error_cnt;
    longint   cycle_cnt;
    bit       calm_stretch;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Step average in Q12, with the full scale code past the last step.
    function automatic longint coarse_val(int i);
        if (i >= COARSE)
            return longint'(CODE_MAX) << 12;
        return longint'(step_avg[i]);
    endfunction

    // Curve point k plus one half, in curve units.
    function automatic longint curve_val(int k);
        int     i;
        int     j;
        longint a;
        longint b;
        i = k / 16;
        j = k % 16;
        if (k >= CURVE_LEN)
            return 16 * (longint'(CODE_MAX) << 12) + CURVE_HALF;
        a = coarse_val(i);
        b = coarse_val(i + 1);
        return 16 * a + (b - a) * j + CURVE_HALF;
    endfunction

    function automatic void rebuild_lut();
        near_pt_t under;
        longint   p;
        longint   q;
        longint   f;
        longint   bq;
        longint   target;
        longint   dl;
        longint   da;
        int       b;
        int       idx;
        int       pick;
        int       seg;
        for (int c = 0; c < BUCKET_CNT; c++)
        begin
            lo_pt[c] = '{0, 0, 0};
            hi_pt[c] = '{0, 0, 0};
        end
        // Drop every fine point into the bucket of the code below it.
        for (int k = 0; k < CURVE_LEN; k++)
        begin
            p = curve_val(k);
            q = curve_val(k + 1);
            for (int j = 0; j < FINE_PER; j++)
            begin
                f   = FINE_PER * p + (q - p) * j;
                idx = k * FINE_PER + j;
                bq  = (f < 0) ? 0 : f / FINE_SCALE;
                b   = (bq > BUCKET_CNT - 1) ? BUCKET_CNT - 1 : int'(bq);
                if (!lo_pt[b].ok || f < lo_pt[b].val)
                    lo_pt[b] = '{1, f, idx};
                if (!hi_pt[b].ok || f > hi_pt[b].val)
                    hi_pt[b] = '{1, f, idx};
            end
        end
        // Carry the nearest point at or above each bucket start downward.
        for (int c = BUCKET_CNT - 1; c > 0; c--)
        begin
            if (lo_pt[c].ok && (!lo_pt[c-1].ok || lo_pt[c].val < lo_pt[c-1].val ||
                (lo_pt[c].val == lo_pt[c-1].val && lo_pt[c].idx < lo_pt[c-1].idx)))
                lo_pt[c-1] = lo_pt[c];
        end
        lut_model[0] = '0;
        under = '{0, 0, 0};
        for (int c = 1; c < TBL_DEPTH; c++)
        begin
            target = longint'(c) * FINE_SCALE;
            if (hi_pt[c-1].ok && (!under.ok || hi_pt[c-1].val > under.val))
                under = hi_pt[c-1];
            if (under.ok && lo_pt[c].ok)
            begin
                dl = target - under.val;
                da = lo_pt[c].val - target;
                if (dl < da)
                    pick = under.idx;
                else if (da < dl)
                    pick = lo_pt[c].idx;
                else
                    pick = (under.idx < lo_pt[c].idx) ? under.idx : lo_pt[c].idx;
            end
            else if (under.ok)
                pick = under.idx;
            else
                pick = lo_pt[c].idx;
            seg = pick / FINE_PER;
            if (seg > int'(CODE_MAX))
                seg = int'(CODE_MAX);
            lut_model[c] = seg[CODE_BITS-1:0];
        end
    endfunction

    // Advance the model by one accepted word; returns 1 with a result.
    function automatic bit predict_word(in_t w, output out_t r);
        longint nv;
        r = '0;
        case (w.mode)
            MODE_SAMPLE:
            begin
                nv = (9 * longint'(step_avg[w.dac_step])
                      + (longint'(w.adc_sample) << 12) + 5) / 10;
                step_avg[w.dac_step] = nv[AVG_BITS-1:0];
                return 0;
            end
            MODE_BUILD:
            begin
                rebuild_lut();
                r.result_kind = KIND_BUILT;
                return 1;
            end
            MODE_READ:
            begin
                r.result_kind    = KIND_ENTRY;
                r.corrected_code = lut_model[w.entry_addr];
                return 1;
            end
            default:
                return 0;
        endcase
    endfunction

    // Offer one word from the falling edge and hold it until taken.
    task automatic send_word(in_t w, bit typed, out_t typed_out);
        out_t predicted;
        bit   has_result;
        @(negedge clk);
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
        has_result = predict_word(w, predicted);
        if (has_result)
            pending_results.push_back(typed ? typed_out : predicted);
    endtask

    // Drop start and hold off until every outstanding word has come back.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Idle the sender: mostly no gap, sometimes short, rarely long.
    task automatic sender_gap();
        int gap;
        if (calm_stretch || $urandom_range(0, 9) < 5)
            gap = 0;
        else if ($urandom_range(0, 9) < 8)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 60);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic in_t mk_word(logic [MODE_BITS-1:0] mode, int stp, int smp, int addr);
        in_t w;
        w.mode       = mode;
        w.dac_step   = stp[STEP_BITS-1:0];
        w.adc_sample = smp[CODE_BITS-1:0];
        w.entry_addr = addr[CODE_BITS-1:0];
        return w;
    endfunction

    // A sample near a slightly bent ramp, or now and then anything at all.
    function automatic in_t rand_sample();
        int stp;
        int smp;
        stp = $urandom_range(0, COARSE - 1);
        if ($urandom_range(0, 9) < 2)
            smp = $urandom_range(0, 4095);
        else
        begin
            smp = stp * 16 + (stp * (255 - stp)) / 64 + $urandom_range(0, 48) - 24;
            if (smp < 0)
                smp = 0;
            if (smp > 4095)
                smp = 4095;
        end
        return mk_word(MODE_SAMPLE, stp, smp, $urandom_range(0, 4095));
    endfunction

    // Check each strobed word against the oldest expectation.
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && result_strobe)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: kind %0d code %0d",
                       result.result_kind, result.corrected_code);
                error_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.result_kind !== want.result_kind)
                begin
                    $error("result_kind: expected %0d, got %0d",
                           want.result_kind, result.result_kind);
                    error_cnt++;
                end
                if (result.corrected_code !== want.corrected_code)
                begin
                    $error("corrected_code: expected %0d, got %0d",
                           want.corrected_code, result.corrected_code);
                    error_cnt++;
                end
            end
        end
    end

    // Hard stop if the block hangs.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("adc_linearity_lut_builder regression: fail");
            $finish;
        end
    end

    initial
    begin
        out_t built;
        out_t zero_entry;
        out_t none;
        in_t  w;
        int   pick;
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        error_cnt    = 0;
        cycle_cnt    = 0;
        calm_stretch = 0;
        built        = '{result_kind: KIND_BUILT, corrected_code: '0};
        zero_entry   = '{result_kind: KIND_ENTRY, corrected_code: '0};
        none         = '0;
        for (int i = 0; i < COARSE; i++)
            step_avg[i] = '0;
        for (int i = 0; i < TBL_DEPTH; i++)
            lut_model[i] = '0;

        // Directed part: reads before any build, field extremes, unused
        // mode, untouched steps, build, and reads at both table ends.
        dir_rows.push_back('{mk_word(MODE_READ, 0, 0, 0), 1, zero_entry});
        dir_rows.push_back('{mk_word(MODE_READ, 255, 4095, 4095), 1, zero_entry});
        dir_rows.push_back('{mk_word(MODE_READ, 0, 0, 2730), 1, zero_entry});
        dir_rows.push_back('{mk_word(MODE_SAMPLE, 0, 0, 4095), 0, none});
        dir_rows.push_back('{mk_word(MODE_SAMPLE, 255, 4095, 0), 0, none});
        dir_rows.push_back('{mk_word(MODE_SAMPLE, 255, 4095, 0), 0, none});
        dir_rows.push_back('{mk_word(MODE_SAMPLE, 128, 2048, 0), 0, none});
        dir_rows.push_back('{mk_word(MODE_SAMPLE, 85, 1365, 1365), 0, none});
        dir_rows.push_back('{mk_word(MODE_SAMPLE, 170, 2730, 2730), 0, none});
        dir_rows.push_back('{mk_word(MODE_UNUSED, 255, 4095, 4095), 0, none});
        dir_rows.push_back('{mk_word(MODE_READ, 0, 0, 4095), 1, zero_entry});
        dir_rows.push_back('{mk_word(MODE_BUILD, 255, 4095, 4095), 1, built});
        dir_rows.push_back('{mk_word(MODE_READ, 0, 0, 0), 1, zero_entry});
        dir_rows.push_back('{mk_word(MODE_READ, 0, 0, 1), 0, none});
        dir_rows.push_back('{mk_word(MODE_READ, 0, 0, 2048), 0, none});
        dir_rows.push_back('{mk_word(MODE_READ, 0, 0, 4094), 0, none});
        dir_rows.push_back('{mk_word(MODE_READ, 0, 0, 4095), 0, none});
        dir_rows.push_back('{mk_word(MODE_UNUSED, 0, 0, 0), 0, none});
        dir_rows.push_back('{mk_word(MODE_READ, 255, 4095, 1365), 0, none});

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].typed_out);
            sender_gap();
        end

        // Random part: mostly samples on a noisy ramp, reads at random codes,
        // a few dropped words, and a build every few hundred words.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 100 == 0)
                calm_stretch = ($urandom_range(0, 3) == 0);
            if (n % BUILD_EVERY == BUILD_EVERY - 1)
            begin
                drain_results();
                w = mk_word(MODE_BUILD, $urandom_range(0, 255), $urandom_range(0, 4095),
                            $urandom_range(0, 4095));
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    w = rand_sample();
                else if (pick < 96)
                    w = mk_word(MODE_READ, $urandom_range(0, 255), $urandom_range(0, 4095),
                                $urandom_range(0, 4095));
                else
                    w = mk_word(MODE_UNUSED, $urandom_range(0, 255),
                                $urandom_range(0, 4095), $urandom_range(0, 4095));
            end
            send_word(w, 0, none);
            sender_gap();
        end

        // Final build and a sweep of reads over it.
        drain_results();
        send_word(mk_word(MODE_BUILD, 0, 0, 0), 0, none);
        for (int n = 0; n < 40; n++)
        begin
            send_word(mk_word(MODE_READ, 0, 0, $urandom_range(0, 4095)), 0, none);
            sender_gap();
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (error_cnt == 0)
            $display("adc_linearity_lut_builder regression: pass");
        else
            $display("adc_linearity_lut_builder regression: fail");
        $finish;
    end

endmodule
